FILE: rtl/srl_pkg.sv
`default_nettype none
package srl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = 64;
   localparam int NAME_W      = 32;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_LOADED = 8'd0,
      CSR_SYMBOL_COUNT = 8'd1,
      CSR_NAMES_LENGTH = 8'd2
   } csr_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   // one table slot as stored in the memory
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] length;
      logic [NAME_W-1:0] name_ofs;
      logic              glob_flag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              loaded;
      logic [CNT_W-1:0]  limit;        // low bits of symbol_count, saturated at depth
      logic [NAME_W-1:0] name_area_len;
   } cfg_type;

endpackage
`default_nettype wire

FILE: rtl/srl_ram.sv
`default_nettype none
module srl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

FILE: rtl/srl_walk.sv
`default_nettype none
module srl_walk
   import srl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_command,
   input  wire logic [IDX_W-1:0]  req_entry_index,
   input  wire logic [ADDR_W-1:0] req_entry_start,
   input  wire logic [ADDR_W-1:0] req_entry_length,
   input  wire logic [NAME_W-1:0] req_entry_name_offset,
   input  wire logic              req_entry_global,
   input  wire logic [ADDR_W-1:0] req_query_address,
   output logic                   mem_we,
   output logic [IDX_W-1:0]       mem_waddr,
   output entry_type              mem_wdata,
   output logic [IDX_W-1:0]       mem_raddr,
   input  wire entry_type         mem_rdata,
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output entry_type              rsp_entry,
   output logic                   rsp_name_valid
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  eval_ff, eval_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              have_prev_ff, have_prev_in;
   entry_type         prev_ff, prev_in;
   logic              strobe_ff, strobe_in;
   logic              found_ff, found_in;
   entry_type         entry_ff, entry_in;
   logic              nvalid_ff, nvalid_in;
   logic [ADDR_W-1:0] end_addr;
   logic              is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      eval_ff      <= eval_in;
      addr_ff      <= addr_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      found_ff     <= found_in;
      entry_ff     <= entry_in;
      nvalid_ff    <= nvalid_in;
   end

   // end of the current symbol, wrapping at 64 bits
   assign end_addr = mem_rdata.start_addr + mem_rdata.length;
   assign is_last  = (eval_ff == IDX_W'(cfg.limit - CNT_W'(1)));

   always_comb begin
      state_in     = state_ff;
      eval_in      = eval_ff;
      addr_in      = addr_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      strobe_in    = 1'b0;
      found_in     = found_ff;
      entry_in     = entry_ff;
      mem_we       = 1'b0;
      mem_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            // slot 0 is read speculatively so a walk starts at once
            if (start) begin
               if (req_command == CMD_WRITE) begin
                  mem_we    = 1'b1;
                  strobe_in = 1'b1;
                  found_in  = 1'b0;
                  entry_in  = '0;
               end else if (!cfg.loaded || cfg.limit == '0) begin
                  strobe_in = 1'b1;
                  found_in  = 1'b0;
                  entry_in  = '0;
               end else begin
                  state_in     = ST_WALK;
                  eval_in      = '0;
                  have_prev_in = 1'b0;
                  addr_in      = req_query_address;
               end
            end
         end
         ST_WALK: begin
            mem_raddr = eval_ff + IDX_W'(1);
            if (mem_rdata.start_addr > addr_ff) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               found_in  = have_prev_ff;
               entry_in  = have_prev_ff ? prev_ff : '0;
            end else if (addr_ff < end_addr) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               found_in  = 1'b1;
               entry_in  = mem_rdata;
            end else if (is_last) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               found_in  = 1'b0;
               entry_in  = '0;
            end else begin
               prev_in      = mem_rdata;
               have_prev_in = 1'b1;
               eval_in      = eval_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      nvalid_in = found_in && (entry_in.name_ofs < cfg.name_area_len);
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign mem_waddr            = req_entry_index;
   assign mem_wdata.start_addr = req_entry_start;
   assign mem_wdata.length     = req_entry_length;
   assign mem_wdata.name_ofs   = req_entry_name_offset;
   assign mem_wdata.glob_flag  = req_entry_global;

   assign rsp_strobe     = strobe_ff;
   assign rsp_found      = found_ff;
   assign rsp_entry      = entry_ff;
   assign rsp_name_valid = nvalid_ff;

endmodule
`default_nettype wire

FILE: rtl/symbol_range_lookup_top.sv
`default_nettype none
// Symbol range lookup. A 1024-slot table of symbols (start, length, name
// offset, global flag), sorted by start, lives in one synchronous RAM.
// A write beat (req_command = 0) stores one slot and is answered by an
// all-zero result on the next cycle; writes can be issued back to back.
// A lookup beat walks slots 0..count-1, one RAM read per cycle, and stops
// at the first slot containing the address (start <= addr < start+length,
// wrapping at 64 bits), at the first slot starting above it, which
// reports the previous slot (not found if there is none), or at the last
// slot, not found. busy is high while slots are examined (never, when the
// table is not loaded or empty) and the result beat follows in the next
// cycle. The next beat can be accepted while that result is on the ports.
// The walk is bound by the single RAM read port, one slot per cycle. Each
// result is on the rsp_ ports for exactly one cycle, flagged by
// rsp_strobe; there is no way to stall it, so the receiver must take it
// then. Not-found results have every field zero.
// Registers (csr_index): 0 table_loaded, 1 symbol_count (its low 11 bits,
// saturated at the table depth), 2 name area length. Write them only while
// the block is idle. Table slots never written read back as undefined.
module symbol_range_lookup_top
   import srl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // config write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_command,
   input  wire logic [IDX_W-1:0]      req_entry_index,
   input  wire logic [ADDR_W-1:0]     req_entry_start,
   input  wire logic [ADDR_W-1:0]     req_entry_length,
   input  wire logic [NAME_W-1:0]     req_entry_name_offset,
   input  wire logic                  req_entry_global,
   input  wire logic [ADDR_W-1:0]     req_query_address,
   // result channel
   output logic                       rsp_strobe,
   output logic                       rsp_found,
   output logic [ADDR_W-1:0]          rsp_symbol_start,
   output logic [ADDR_W-1:0]          rsp_symbol_length,
   output logic [NAME_W-1:0]          rsp_symbol_name_offset,
   output logic                       rsp_name_valid,
   output logic                       rsp_symbol_global
);

   // ---- configuration registers ----
   logic              loaded_ff, loaded_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [NAME_W-1:0] names_len_ff, names_len_in;
   logic [CNT_W-1:0]  count_wr;
   cfg_type           cfg;

   assign csr_ready = 1'b1;
   assign count_wr  = csr_wdata[CNT_W-1:0];

   always_comb begin
      loaded_in    = loaded_ff;
      limit_in     = limit_ff;
      names_len_in = names_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_LOADED: loaded_in = csr_wdata[0];
            // saturate once here so the walker only sees a legal count
            CSR_SYMBOL_COUNT: limit_in = (count_wr > CNT_W'(TABLE_DEPTH)) ?
                                         CNT_W'(TABLE_DEPTH) : count_wr;
            CSR_NAMES_LENGTH: names_len_in = csr_wdata[NAME_W-1:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         limit_ff     <= '0;
         names_len_ff <= '0;
      end else begin
         loaded_ff    <= loaded_in;
         limit_ff     <= limit_in;
         names_len_ff <= names_len_in;
      end
   end

   assign cfg.loaded        = loaded_ff;
   assign cfg.limit         = limit_ff;
   assign cfg.name_area_len = names_len_ff;

   // ---- table RAM and walker ----
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_wdata;
   entry_type        mem_rdata;
   entry_type        rsp_entry;

   // A write is stored at its accept edge and a lookup cannot be taken in
   // that same cycle, so the walk never reads a slot mid-update.
   srl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   srl_walk u_walk (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_entry_index       (req_entry_index),
      .req_entry_start       (req_entry_start),
      .req_entry_length      (req_entry_length),
      .req_entry_name_offset (req_entry_name_offset),
      .req_entry_global      (req_entry_global),
      .req_query_address     (req_query_address),
      .mem_we                (mem_we),
      .mem_waddr             (mem_waddr),
      .mem_wdata             (mem_wdata),
      .mem_raddr             (mem_raddr),
      .mem_rdata             (mem_rdata),
      .rsp_strobe            (rsp_strobe),
      .rsp_found             (rsp_found),
      .rsp_entry             (rsp_entry),
      .rsp_name_valid        (rsp_name_valid)
   );

   assign rsp_symbol_start       = rsp_entry.start_addr;
   assign rsp_symbol_length      = rsp_entry.length;
   assign rsp_symbol_name_offset = rsp_entry.name_ofs;
   assign rsp_symbol_global      = rsp_entry.glob_flag;

   // ---- checks ----
   // a result beat never overlaps a running walk
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while walker busy");

   // every write beat is answered on the next cycle
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_WRITE) |=> (rsp_strobe && !rsp_found))
      else $error("write beat not answered");

   // lookups with no table loaded fail at once
   a_unloaded: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_LOOKUP && !loaded_ff)
      |=> (rsp_strobe && !rsp_found))
      else $error("unloaded lookup did not fail at once");

   // a not-found beat carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_entry == '0 && !rsp_name_valid))
      else $error("not-found result has nonzero payload");

endmodule
`default_nettype wire
